FILE: hw/rtl/gdd_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date difference block.
// No dependencies; used by gdd_lane, gdd_merge and gregorian_date_difference.
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DN_W    = 23;   // day number and difference width
    localparam int MOFS_W  = 9;    // days before month, up to 335

    localparam int                 MAX_YEAR  = 9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(q / 25) == (q * RECIP25) >> RECIP25_SHIFT for q < 4096
    localparam logic [10:0] RECIP25       = 11'd1311;
    localparam int          RECIP25_SHIFT = 15;

    typedef logic [DN_W-1:0] dnum_t;

    typedef struct packed {
        logic  valid;   // date exists
        logic  leap;    // year is a leap year
        dnum_t dnum;    // proleptic day number, meaningful when valid
    } lane_result_t;

    // Length of a month in a common year; 0 for months out of range.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before m, common year; 0 for months out of range.
    function automatic logic [MOFS_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [MOFS_W-1:0] ofs;
        case (m)
            4'd1:    ofs = 9'd0;
            4'd2:    ofs = 9'd31;
            4'd3:    ofs = 9'd59;
            4'd4:    ofs = 9'd90;
            4'd5:    ofs = 9'd120;
            4'd6:    ofs = 9'd151;
            4'd7:    ofs = 9'd181;
            4'd8:    ofs = 9'd212;
            4'd9:    ofs = 9'd243;
            4'd10:   ofs = 9'd273;
            4'd11:   ofs = 9'd304;
            4'd12:   ofs = 9'd334;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

FILE: hw/rtl/gdd_lane.sv
// One date lane: validity check, leap rule and day number over two register stages.
// Depends on gdd_pkg; instantiated twice by gregorian_date_difference.
module gdd_lane #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR
) (
    input  logic                          clk,
    input  logic                          en1,    // load stage 1
    input  logic                          en2,    // load stage 2
    input  logic [gdd_pkg::DAY_W-1:0]     day,
    input  logic [gdd_pkg::MONTH_W-1:0]   month,
    input  logic [gdd_pkg::YEAR_W-1:0]    year,
    output gdd_pkg::lane_result_t         result
);

    localparam int Q_W   = gdd_pkg::YEAR_W - 2;   // year / 4
    localparam int C_W   = 8;                     // year / 100
    localparam int PR_W  = Q_W + 11;              // reciprocal product

    // ---- stage 1 combinational ----
    logic [gdd_pkg::YEAR_W-1:0] p;
    logic [Q_W-1:0]             pq;
    logic [PR_W-1:0]            p_prod;
    logic [C_W-1:0]             pc;
    logic [Q_W-1:0]             yq;
    logic [PR_W-1:0]            y_prod;
    logic [C_W-1:0]             yc;
    logic [Q_W-1:0]             yr;
    logic                       div4;
    logic                       div100;
    logic                       leap;
    logic [gdd_pkg::DAY_W:0]    len;
    logic                       ok;
    logic [gdd_pkg::MOFS_W-1:0] mofs;

    always_comb
    begin
        p      = year - 1'b1;
        pq     = p[gdd_pkg::YEAR_W-1:2];
        p_prod = PR_W'(pq) * PR_W'(gdd_pkg::RECIP25);
        pc     = p_prod[gdd_pkg::RECIP25_SHIFT +: C_W];

        yq     = year[gdd_pkg::YEAR_W-1:2];
        y_prod = PR_W'(yq) * PR_W'(gdd_pkg::RECIP25);
        yc     = y_prod[gdd_pkg::RECIP25_SHIFT +: C_W];
        yr     = yq - Q_W'(yc) * Q_W'(25);

        div4   = (year[1:0] == 2'b00);
        div100 = div4 && (yr == '0);
        leap   = (div4 && !div100) || (div100 && (yc[1:0] == 2'b00));

        len = {1'b0, gdd_pkg::month_len(month)};
        if (month == gdd_pkg::MONTH_FEB && leap)
        begin
            len = len + 1'b1;
        end

        ok = (day != '0) && (month >= gdd_pkg::MONTH_JAN) && (month <= gdd_pkg::MONTH_DEC)
             && (year != '0) && (int'(year) <= MAX_YEAR)
             && ({1'b0, day} <= len);

        mofs = gdd_pkg::days_before(month);
        if (month > gdd_pkg::MONTH_FEB && leap)
        begin
            mofs = mofs + 1'b1;
        end
    end

    // ---- stage 1 registers ----
    gdd_pkg::dnum_t             p365_reg;
    logic [Q_W-1:0]             pq_reg;
    logic [C_W-1:0]             pc_reg;
    logic [gdd_pkg::MOFS_W-1:0] mofs_reg;
    logic [gdd_pkg::DAY_W-1:0]  day_reg;
    logic                       ok_reg;
    logic                       leap_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p365_reg <= gdd_pkg::dnum_t'(p) * gdd_pkg::dnum_t'(365);
            pq_reg   <= pq;
            pc_reg   <= pc;
            mofs_reg <= mofs;
            day_reg  <= day;
            ok_reg   <= ok;
            leap_reg <= leap;
        end
    end

    // ---- stage 2: sum of the day number terms ----
    gdd_pkg::dnum_t       dnum_next;
    gdd_pkg::lane_result_t result_reg;

    always_comb
    begin
        dnum_next = p365_reg + gdd_pkg::dnum_t'(pq_reg) - gdd_pkg::dnum_t'(pc_reg)
                  + gdd_pkg::dnum_t'(pc_reg[C_W-1:2]) + gdd_pkg::dnum_t'(mofs_reg)
                  + gdd_pkg::dnum_t'(day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            result_reg.valid <= ok_reg;
            result_reg.leap  <= leap_reg;
            result_reg.dnum  <= dnum_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: hw/rtl/gdd_merge.sv
// Merge stage: subtracts the two lane day numbers and registers the result fields.
// Depends on gdd_pkg; fed by two gdd_lane instances.
module gdd_merge (
    input  logic                          clk,
    input  logic                          en,
    input  gdd_pkg::lane_result_t         lane_a,
    input  gdd_pkg::lane_result_t         lane_b,
    output logic                          first_valid,
    output logic                          second_valid,
    output logic                          first_leap,
    output logic signed [gdd_pkg::DN_W-1:0] day_difference
);

    logic                              first_valid_reg;
    logic                              second_valid_reg;
    logic                              first_leap_reg;
    logic signed [gdd_pkg::DN_W-1:0]   diff_reg;
    logic signed [gdd_pkg::DN_W-1:0]   diff_next;

    // invalid on either side forces zero
    always_comb
    begin
        if (lane_a.valid && lane_b.valid)
        begin
            diff_next = signed'(lane_a.dnum - lane_b.dnum);
        end
        else
        begin
            diff_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            first_valid_reg  <= lane_a.valid;
            second_valid_reg <= lane_b.valid;
            first_leap_reg   <= lane_a.leap;
            diff_reg         <= diff_next;
        end
    end

    assign first_valid    = first_valid_reg;
    assign second_valid   = second_valid_reg;
    assign first_leap     = first_leap_reg;
    assign day_difference = diff_reg;

endmodule

FILE: hw/rtl/gregorian_date_difference.sv
// Top level of the Gregorian date difference block: handshake control, two date lanes, merge.
// Depends on gdd_pkg, gdd_lane and gdd_merge.
//
// Each transfer on the input carries two calendar dates. Two identical lanes check each date
// (day, month 1..12, year 1..MAX_YEAR, 29 February only in leap years by the 4/100/400 rule)
// and form its proleptic day number; the merge stage returns both validity flags, the leap
// flag of the first year (year 0 counts as leap) and day number 1 minus day number 2 as a
// 23-bit two's complement value, zero when either date is invalid. Throughput is one item
// per cycle as long as out_ready does not stall the output; items pass through three register
// stages (lane decode with the constant-reciprocal divisions, lane day-number sum,
// merge subtract). Each stage holds its item only while the next one is full and stalled,
// so an empty stage still takes an item while a finished result waits for out_ready.
module gregorian_date_difference #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gdd_pkg::DAY_W-1:0]           first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]         first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]          first_year,
    input  logic [gdd_pkg::DAY_W-1:0]           second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]         second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]          second_year,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                first_valid,
    output logic                                second_valid,
    output logic                                first_leap,
    output logic signed [gdd_pkg::DN_W-1:0]     day_difference
);

    // occupancy of the three stages
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    // a stage may load when it is empty or its content moves on this cycle
    logic adv1;
    logic adv2;
    logic adv3;

    assign adv3     = !out_valid_reg || out_ready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    gdd_pkg::lane_result_t lane_a;
    gdd_pkg::lane_result_t lane_b;

    // lane for the first date
    gdd_lane #(
        .MAX_YEAR (MAX_YEAR)
    ) u_lane_a (
        .clk    (clk),
        .en1    (adv1 && in_valid),
        .en2    (adv2 && s1_valid_reg),
        .day    (first_day),
        .month  (first_month),
        .year   (first_year),
        .result (lane_a)
    );

    // lane for the second date
    gdd_lane #(
        .MAX_YEAR (MAX_YEAR)
    ) u_lane_b (
        .clk    (clk),
        .en1    (adv1 && in_valid),
        .en2    (adv2 && s1_valid_reg),
        .day    (second_day),
        .month  (second_month),
        .year   (second_year),
        .result (lane_b)
    );

    // difference and output register
    gdd_merge u_merge (
        .clk            (clk),
        .en             (adv3 && s2_valid_reg),
        .lane_a         (lane_a),
        .lane_b         (lane_b),
        .first_valid    (first_valid),
        .second_valid   (second_valid),
        .first_leap     (first_leap),
        .day_difference (day_difference)
    );

endmodule
